[hdl/irpwfr_pkg.sv]
// ----------------------------------------------------------------------------
// irpwfr_pkg
// Types and constants shared by the IR pulse-width frame receiver.
// ----------------------------------------------------------------------------
package irpwfr_pkg;

	// default word length in bits
	localparam int WORD_BITS_DEF = 16;

	// gap thresholds in microseconds, before the mark time is subtracted
	localparam int unsigned T_LOW   = 316;
	localparam int unsigned T_HIGH  = 526;
	localparam int unsigned T_STOP  = 947;
	localparam int unsigned T_START = 1579;
	localparam int unsigned MIN_MARK = 100;
	localparam logic [3:0] LRC_SEED = 4'hF;

	localparam logic [8:0] MARK_DUR_RST = 9'd158;

	// config port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	typedef enum logic [0:0] {
		REG_MARK_DUR = 1'b0
	} reg_idx_t;

	typedef struct packed {
		logic        is_mark;
		logic [15:0] duration_us;
	} in_item_t;

	typedef struct packed {
		logic        new_message;
		logic [15:0] message_word;
		logic        receiving;
	} out_item_t;

	// step request from the pipeline into the decoder
	typedef struct packed {
		logic     step;
		in_item_t item;
	} core_ctl_t;

endpackage

[hdl/irpwfr_regs.sv]
// ----------------------------------------------------------------------------
// irpwfr_regs
// APB-style register file: holds the mark time.
// ----------------------------------------------------------------------------
module irpwfr_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [irpwfr_pkg::PADDR_W-1:0]    paddr,
	input  logic [irpwfr_pkg::PDATA_W-1:0]    pwdata,
	output logic [irpwfr_pkg::PDATA_W-1:0]    prdata,
	output logic                              pready,
	output logic [8:0]                        mark_dur
);

	logic [8:0] mark_dur_q;
	logic       sel_mark;

	// register index is the word address
	assign sel_mark = (paddr[2] == irpwfr_pkg::REG_MARK_DUR);
	assign pready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_dur_q <= irpwfr_pkg::MARK_DUR_RST;
		end else if (psel && penable && pwrite && sel_mark) begin
			mark_dur_q <= pwdata[8:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_mark) begin
			prdata = {{(irpwfr_pkg::PDATA_W-9){1'b0}}, mark_dur_q};
		end
	end

	assign mark_dur = mark_dur_q;

endmodule

[hdl/irpwfr_core.sv]
// ----------------------------------------------------------------------------
// irpwfr_core
// Frame decoder: classifies one pulse and updates the frame state.
// ----------------------------------------------------------------------------
module irpwfr_core #(
	parameter int WORD_BITS = irpwfr_pkg::WORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [8:0]            mark_dur,
	input  irpwfr_pkg::core_ctl_t ctl,
	output irpwfr_pkg::out_item_t result
);

	localparam int NIBBLES = (WORD_BITS + 3) / 4;
	localparam int PAD_W   = NIBBLES * 4;
	localparam int EXT_W   = (WORD_BITS > 16) ? WORD_BITS : 16;

	logic                 reading_q;
	logic [WORD_BITS-1:0] shift_q;
	logic [4:0]           count_q;
	logic [WORD_BITS-1:0] last_q;

	logic                 reading_d;
	logic [WORD_BITS-1:0] shift_d;
	logic [4:0]           count_d;
	logic [WORD_BITS-1:0] last_d;
	logic                 fresh;

	logic [16:0]          sum;       // duration + mark time
	logic                 is_low, is_high, is_stop, is_start;
	logic [PAD_W-1:0]     padded;
	logic [3:0]           lrc;
	logic                 lrc_ok;
	logic [EXT_W-1:0]     last_ext;

	// t >= T - m  <=>  t + m >= T, no signed math needed
	assign sum      = {1'b0, ctl.item.duration_us} + {8'd0, mark_dur};
	assign is_low   = (sum >= 17'(irpwfr_pkg::T_LOW))  && (sum <= 17'(irpwfr_pkg::T_HIGH));
	assign is_high  = (sum >= 17'(irpwfr_pkg::T_HIGH)) && (sum <= 17'(irpwfr_pkg::T_STOP));
	assign is_stop  = (sum >= 17'(irpwfr_pkg::T_STOP)) && (sum <= 17'(irpwfr_pkg::T_START));
	assign is_start = (sum >= 17'(irpwfr_pkg::T_START));

	// check nibble: seed xor every nibble above the lowest
	assign padded = PAD_W'(shift_q);
	always_comb begin
		lrc = irpwfr_pkg::LRC_SEED;
		for (int n = 1; n < NIBBLES; n++) begin
			lrc = lrc ^ padded[4*n +: 4];
		end
	end
	assign lrc_ok = (lrc == padded[3:0]);

	always_comb begin
		reading_d = reading_q;
		shift_d   = shift_q;
		count_d   = count_q;
		last_d    = last_q;
		fresh     = 1'b0;
		if (ctl.item.is_mark) begin
			if (ctl.item.duration_us < 16'(irpwfr_pkg::MIN_MARK) && reading_q) begin
				reading_d = 1'b0;
				shift_d   = '0;
				count_d   = '0;
				last_d    = '0;
			end
		end else if (reading_q) begin
			if (is_low || is_high) begin
				// low wins on the shared boundary
				shift_d = {shift_q[WORD_BITS-2:0], !is_low};
				if (count_q != 5'd31) begin
					count_d = count_q + 5'd1;
				end
			end else if (is_stop && lrc_ok) begin
				fresh   = (last_q != shift_q);
				last_d  = shift_q;
				shift_d = '0;
				count_d = '0;
			end else begin
				reading_d = 1'b0;
				shift_d   = '0;
				count_d   = '0;
				last_d    = '0;
			end
		end else if (is_start) begin
			reading_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reading_q <= 1'b0;
			shift_q   <= '0;
			count_q   <= '0;
			last_q    <= '0;
		end else if (ctl.step) begin
			reading_q <= reading_d;
			shift_q   <= shift_d;
			count_q   <= count_d;
			last_q    <= last_d;
		end
	end

	assign last_ext            = EXT_W'(last_d);
	assign result.new_message  = fresh;
	assign result.message_word = last_ext[15:0];
	assign result.receiving    = reading_d;

	// bits above the received count are still zero
	a_shift_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q < 5'(WORD_BITS)) |-> ((PAD_W'(shift_q) >> count_q) == '0))
		else $error("shift word has bits above bit count");
	// while waiting, nothing is collected
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!reading_q |-> (shift_q == '0 && count_q == '0 && last_q == '0))
		else $error("idle decoder holds frame data");

endmodule

[hdl/ir_pulse_width_frame_receiver.sv]
// ----------------------------------------------------------------------------
// ir_pulse_width_frame_receiver
// Pulse-distance IR remote decoder with a 4-bit check nibble.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_stall/in_data): one measured pulse per
//    transfer, mark or gap, length in microseconds.
//  - Output channel (out_valid/out_stall/out_data): exactly one result per
//    pulse: new-message flag, last accepted word, receiving status.
//  - Config port (APB style): register 0 at byte address 0 is the mark time
//    subtracted from all gap thresholds. Write only while idle.
//  - The input register takes the pulse at its transfer edge; the result
//    register takes it once it is free, so out_valid rises only after the
//    pulse has passed both registers. One pulse per cycle while out_stall
//    is low; the decoder compares and updates its state combinationally,
//    stepped when its result is stored.
//  - Reset clears the frame state (waiting for start), the valid flags of
//    both pipeline registers, and loads the mark time default of 158 us.
//  - When the receiver stalls, the result register holds its transfer; the
//    input register still takes one more pulse, then in_stall rises.
// ----------------------------------------------------------------------------
module ir_pulse_width_frame_receiver #(
	parameter int WORD_BITS = irpwfr_pkg::WORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// pulse input
	input  logic                           in_valid,
	output logic                           in_stall,
	input  irpwfr_pkg::in_item_t           in_data,
	// decode results
	output logic                           out_valid,
	input  logic                           out_stall,
	output irpwfr_pkg::out_item_t          out_data,
	// configuration
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [irpwfr_pkg::PADDR_W-1:0] paddr,
	input  logic [irpwfr_pkg::PDATA_W-1:0] pwdata,
	output logic [irpwfr_pkg::PDATA_W-1:0] prdata,
	output logic                           pready
);

	logic                   valid_s1;
	irpwfr_pkg::in_item_t   item_s1;
	logic                   out_valid_q;
	irpwfr_pkg::out_item_t  out_q;
	logic                   advance;     // s1 item moves into the result register
	logic                   in_take;
	logic [8:0]             mark_dur;
	irpwfr_pkg::core_ctl_t  core_ctl;
	irpwfr_pkg::out_item_t  core_result;

	// result register frees up when empty or when its transfer completes
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	irpwfr_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.mark_dur  (mark_dur)
	);

	assign core_ctl.step = advance;
	assign core_ctl.item = item_s1;

	// decoder state updates exactly when its result is stored
	irpwfr_core #(
		.WORD_BITS (WORD_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.mark_dur  (mark_dur),
		.ctl       (core_ctl),
		.result    (core_result)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take || advance) begin
			valid_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= in_data;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= core_result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// a new message is only reported with reception armed
	a_new_armed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.new_message) |-> out_q.receiving)
		else $error("new message reported while waiting for start");
	// abort or idle clears the reported word
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.receiving) |-> (out_q.message_word == 16'd0))
		else $error("nonzero word while waiting for start");
	// a held result blocks the pipeline once the input register is full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && out_stall) |-> in_stall)
		else $error("input taken with full pipeline");

endmodule
